>>> rtl/cbr_pkg.sv
// package: constants and register codes for the cubic root bisection core
package cbr_pkg;

  // default configuration of the search
  localparam int unsigned ITERATIONS_DEF  = 24;
  localparam int unsigned UPPER_BOUND_DEF = 30;

  // number formats
  localparam int unsigned COEF_W  = 32;           // Q16.16 coefficients and constant term
  localparam int unsigned TOL_W   = 16;           // tolerance width
  localparam int unsigned ACC_W   = 64;           // Horner accumulator width
  localparam int unsigned HALF_W  = 32;           // multiplier operand width
  localparam int unsigned FRAC_X  = 19;           // fraction bits of the abscissa
  localparam int unsigned P1_SH   = HALF_W - FRAC_X;  // left shift of the high partial product
  localparam int unsigned P1_TOP  = ACC_W - 1 - P1_SH;  // high partial product must stay below 2^P1_TOP
  localparam int unsigned ROOT_W  = 5;
  localparam int unsigned ROOT_MAX = 31;

  // register reset values
  localparam logic signed [COEF_W-1:0] COEF_CUBIC_RST  = 32'sd0;
  localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = 32'sd0;
  localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = 32'sd65536;
  localparam logic [TOL_W-1:0]         TOLERANCE_RST   = 16'd7;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_COEF_CUBIC  = 2'd0,
    CFG_COEF_SQUARE = 2'd1,
    CFG_COEF_LINEAR = 2'd2,
    CFG_TOLERANCE   = 2'd3
  } cfg_reg_e;

endpackage

>>> rtl/cubic_root_bisection_core.sv
// top level: bisection root finder for a cubic with one shared 32-bit by abscissa multiplier
// a search runs up to ITERATIONS bisection steps, each three Horner passes and a decide step,
//   from input transaction to result, plus any stall on a waiting result; converging ends early
// items are taken one at a time, since the search holds the single shared multiplier; a new
//   item may be taken while the previous result still waits on the output register
// reset clears control and loads the coefficient registers; no memory, no clearing pass
module cubic_root_bisection_core
  import cbr_pkg::*;
#(
  parameter int unsigned ITERATIONS  = ITERATIONS_DEF,
  parameter int unsigned UPPER_BOUND = UPPER_BOUND_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [COEF_W-1:0]        cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [COEF_W-1:0] constant_term_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ROOT_W-1:0]        root_rounded_o,
  output logic                     converged_o
);

  // abscissa width follows the upper bound of the search interval
  localparam int unsigned X_W   = $clog2(UPPER_BOUND + 1) + FRAC_X;
  localparam int unsigned P_W   = HALF_W + X_W;        // partial product width
  localparam int unsigned IT_W  = $clog2(ITERATIONS);
  localparam int unsigned RND_W = X_W + 1 - FRAC_X;    // rounded root before clamping
  localparam int unsigned RX_W  = (RND_W > ROOT_W) ? RND_W : ROOT_W;

  localparam logic [X_W-1:0]      HI_INIT  = X_W'(UPPER_BOUND) << FRAC_X;
  localparam logic [X_W:0]        RND_HALF = (X_W + 1)'(1) << (FRAC_X - 1);
  localparam logic [IT_W-1:0]     IT_LAST  = IT_W'(ITERATIONS - 1);
  localparam logic [ACC_W-2:0]    SAT_MAG  = {(ACC_W - 1){1'b1}};
  localparam logic signed [ACC_W:0] SAT_POS = {2'b00, SAT_MAG};
  localparam logic signed [ACC_W:0] SAT_NEG = -SAT_POS;

  // sequencer: mag -> mulh -> mull -> scale -> add, three times, then decide
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_MULH,
    ST_MULL,
    ST_SCALE,
    ST_ADD,
    ST_DECIDE
  } state_e;

  state_e state_q;
  logic [1:0]      step_q;     // Horner step within one polynomial evaluation
  logic [IT_W-1:0] it_q;       // bisection step count

  // configuration registers
  logic signed [COEF_W-1:0] coef_cubic_q, coef_square_q, coef_linear_q;
  logic [TOL_W-1:0]         tol_q;

  // datapath registers
  logic [X_W-1:0]           lo_q, hi_q, mid_q;
  logic signed [ACC_W-1:0]  flo_q;    // value kept for the lower end
  logic signed [ACC_W-1:0]  acc_q;    // Horner accumulator
  logic signed [COEF_W-1:0] d_q;
  logic                     neg_q;
  logic [ACC_W-1:0]         mag_q;
  logic [P_W-1:0]           p1_q, p0_q;
  logic [ACC_W-2:0]         s_q;      // saturated product magnitude

  // result registers
  logic                     out_valid_q;
  logic [ROOT_W-1:0]        root_q;
  logic                     conv_q;

  logic in_accept;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_cubic_q  <= COEF_CUBIC_RST;
      coef_square_q <= COEF_SQUARE_RST;
      coef_linear_q <= COEF_LINEAR_RST;
      tol_q         <= TOLERANCE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_COEF_CUBIC:  coef_cubic_q  <= cfg_data_i;
        CFG_COEF_SQUARE: coef_square_q <= cfg_data_i;
        CFG_COEF_LINEAR: coef_linear_q <= cfg_data_i;
        CFG_TOLERANCE:   tol_q         <= cfg_data_i[TOL_W-1:0];
      endcase
    end
  end

  // shared multiplier: high half of the magnitude in mulh, low half in mull
  logic [HALF_W-1:0] mul_a;
  logic [P_W-1:0]    prod;
  assign mul_a = (state_q == ST_MULH) ? mag_q[ACC_W-1:HALF_W] : mag_q[HALF_W-1:0];
  assign prod  = P_W'(mul_a) * P_W'(mid_q);

  // scale: (p1 << 13) + (p0 >> 19), saturating on the magnitude
  logic             p1_big;
  logic [ACC_W-1:0] scaled;
  logic [ACC_W-2:0] s_d;
  assign p1_big = |p1_q[P_W-1:P1_TOP];
  assign scaled = {1'b0, p1_q[P1_TOP-1:0], {P1_SH{1'b0}}} + ACC_W'(p0_q[P_W-1:FRAC_X]);
  assign s_d    = (p1_big || scaled[ACC_W-1]) ? SAT_MAG : scaled[ACC_W-2:0];

  // add: signed product plus next coefficient, saturating to +-(2^63 - 1)
  logic signed [COEF_W-1:0] add_coef;
  logic signed [ACC_W:0]    coef_ext, prod_ext, add_sum;
  logic signed [ACC_W-1:0]  add_d;
  always_comb begin
    unique case (step_q)
      2'd0:    add_coef = coef_square_q;
      2'd1:    add_coef = coef_linear_q;
      default: add_coef = d_q;
    endcase
    coef_ext = {{(ACC_W + 1 - COEF_W){add_coef[COEF_W-1]}}, add_coef};
    prod_ext = {2'b00, s_q};
    add_sum  = neg_q ? (coef_ext - prod_ext) : (coef_ext + prod_ext);
    if (add_sum > SAT_POS) begin
      add_d = SAT_POS[ACC_W-1:0];
    end else if (add_sum < SAT_NEG) begin
      add_d = SAT_NEG[ACC_W-1:0];
    end else begin
      add_d = add_sum[ACC_W-1:0];
    end
  end

  // decide: sign test, tolerance test and the next interval
  logic signed [ACC_W-1:0] tol_ext;
  logic                    sign_chg, conv, finished, stall;
  logic [X_W-1:0]          lo_d, hi_d;
  logic signed [ACC_W-1:0] flo_d;
  logic [X_W:0]            mid_sum;
  always_comb begin
    tol_ext  = {{(ACC_W - TOL_W){1'b0}}, tol_q};
    sign_chg = ((acc_q < 0) && (flo_q > 0)) || ((acc_q > 0) && (flo_q < 0));
    conv     = (acc_q < tol_ext) && (acc_q > -tol_ext);
    finished = conv || (it_q == IT_LAST);
    stall    = finished && out_valid_q && !out_ready_i;
    lo_d     = lo_q;
    hi_d     = hi_q;
    flo_d    = flo_q;
    if (sign_chg) begin
      hi_d = mid_q;
    end else begin
      lo_d  = mid_q;
      flo_d = acc_q;
    end
    mid_sum = {1'b0, lo_d} + {1'b0, hi_d};
  end

  // result valid: set when a search finishes, cleared when the result is taken
  logic result_load, out_valid_d;
  assign result_load = (state_q == ST_DECIDE) && finished && !stall;
  assign out_valid_d = result_load || (out_valid_q && !out_ready_i);

  // rounding of the final midpoint, half up, clamped to the field range
  logic [X_W:0]      rnd_sum;
  logic [RX_W-1:0]   rnd_ext;
  logic [ROOT_W-1:0] root_d;
  assign rnd_sum = {1'b0, mid_q} + RND_HALF;
  assign rnd_ext = RX_W'(rnd_sum[X_W:FRAC_X]);
  assign root_d  = (rnd_ext > RX_W'(ROOT_MAX)) ? ROOT_W'(ROOT_MAX) : rnd_ext[ROOT_W-1:0];

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 2'd0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
      root_q      <= '0;
      conv_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            step_q  <= 2'd0;
            it_q    <= '0;
            state_q <= ST_MAG;
          end
        end
        ST_MAG:   state_q <= ST_MULH;
        ST_MULH:  state_q <= ST_MULL;
        ST_MULL:  state_q <= ST_SCALE;
        ST_SCALE: state_q <= ST_ADD;
        ST_ADD: begin
          if (step_q == 2'd2) begin
            state_q <= ST_DECIDE;
          end else begin
            step_q  <= step_q + 2'd1;
            state_q <= ST_MAG;
          end
        end
        ST_DECIDE: begin
          if (!stall) begin
            step_q <= 2'd0;
            if (finished) begin
              root_q  <= root_d;
              conv_q  <= conv;
              state_q <= ST_IDLE;
            end else begin
              it_q    <= it_q + IT_W'(1);
              state_q <= ST_MAG;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          lo_q  <= '0;
          hi_q  <= HI_INIT;
          mid_q <= HI_INIT >> 1;
          d_q   <= constant_term_i;
          flo_q <= {{(ACC_W - COEF_W){constant_term_i[COEF_W-1]}}, constant_term_i};
          acc_q <= {{(ACC_W - COEF_W){coef_cubic_q[COEF_W-1]}}, coef_cubic_q};
        end
      end
      ST_MAG: begin
        neg_q <= acc_q[ACC_W-1];
        mag_q <= acc_q[ACC_W-1] ? -acc_q : acc_q;
      end
      ST_MULH:  p1_q  <= prod;
      ST_MULL:  p0_q  <= prod;
      ST_SCALE: s_q   <= s_d;
      ST_ADD:   acc_q <= add_d;
      ST_DECIDE: begin
        if (!stall) begin
          lo_q  <= lo_d;
          hi_q  <= hi_d;
          flo_q <= flo_d;
          mid_q <= mid_sum[X_W:1];
          acc_q <= {{(ACC_W - COEF_W){coef_cubic_q[COEF_W-1]}}, coef_cubic_q};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign root_rounded_o = root_q;
  assign converged_o    = conv_q;

`ifndef ASSERT_OFF
  // an accepted transaction starts the first magnitude step
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_MAG))
    else $error("accepted transaction did not start evaluation");

  // the interval never inverts while a search is running
  a_interval_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (hi_q >= lo_q) && (mid_q >= lo_q) && (mid_q <= hi_q))
    else $error("bisection interval out of order");

  // saturation keeps the accumulator off the most negative code
  a_acc_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (acc_q != {1'b1, {(ACC_W - 1){1'b0}}}))
    else $error("accumulator reached the unsaturated negative limit");

  // a zero tolerance can never report convergence
  a_conv_needs_tol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && converged_o) |-> (tol_q != '0))
    else $error("converged with zero tolerance");

  // a result waiting on the output is never overwritten
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(root_q) && $stable(conv_q))
    else $error("pending result changed");
`endif

endmodule

>>> tb/sv/cbr_checker.sv
// checker module: predicts and compares results of the cubic root bisection core
`timescale 1ns / 1ps
module cbr_checker
  import cbr_pkg::*;
#(
  parameter int unsigned ITERATIONS  = ITERATIONS_DEF,
  parameter int unsigned UPPER_BOUND = UPPER_BOUND_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [COEF_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [COEF_W-1:0] constant_term_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [ROOT_W-1:0]        root_rounded_i,
  input  logic                     converged_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam longint    SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] SAT_U   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              conv;
  } root_expect_t;

  root_expect_t             expected_roots[$];
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;
  logic [TOL_W-1:0]         tol;
  int                       fails;
  int                       pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic longint sat_sum(longint p, longint q);
    if (q > 0 && p > SAT_MAX - q) return SAT_MAX;
    if (q < 0 && p < -SAT_MAX - q) return -SAT_MAX;
    return p + q;
  endfunction

  // acc * x >> FRAC_X, magnitude truncated, saturating
  function automatic longint scale_by_x(longint acc, bit [63:0] x);
    bit        neg;
    bit [63:0] mag, hi_part, lo_part, sum;
    neg     = acc < 0;
    mag     = neg ? 64'(-acc) : 64'(acc);
    hi_part = (mag >> 32) * x;
    lo_part = {32'd0, mag[31:0]} * x;
    if (hi_part > (SAT_U >> P1_SH)) begin
      sum = SAT_U;
    end else begin
      sum = (hi_part << P1_SH) + (lo_part >> FRAC_X);
      if (sum > SAT_U || sum < (hi_part << P1_SH)) sum = SAT_U;
    end
    return neg ? -longint'(sum) : longint'(sum);
  endfunction

  function automatic longint poly_at(longint d, bit [63:0] x);
    longint acc;
    acc = longint'(coef_a);
    acc = sat_sum(scale_by_x(acc, x), longint'(coef_b));
    acc = sat_sum(scale_by_x(acc, x), longint'(coef_c));
    return sat_sum(scale_by_x(acc, x), d);
  endfunction

  function automatic root_expect_t bisect_root(logic signed [COEF_W-1:0] d_in);
    bit [63:0]    lo, hi, mid, rnd;
    longint       d, flo, fm, mag;
    logic         conv;
    int           step;
    root_expect_t r;
    d    = longint'(d_in);
    lo   = 64'd0;
    hi   = 64'(UPPER_BOUND) << FRAC_X;
    mid  = 64'd0;
    flo  = d;
    conv = 1'b0;
    step = 0;
    while (step < ITERATIONS && !conv) begin
      mid = (lo + hi) >> 1;
      fm  = poly_at(d, mid);
      // only a strict sign change moves the upper end
      if ((fm < 0 && flo > 0) || (fm > 0 && flo < 0)) begin
        hi = mid;
      end else begin
        lo  = mid;
        flo = fm;
      end
      mag = fm < 0 ? -fm : fm;
      if (mag < longint'(tol)) conv = 1'b1;
      step++;
    end
    rnd = (mid + (64'd1 << (FRAC_X - 1))) >> FRAC_X;
    if (rnd > ROOT_MAX) rnd = ROOT_MAX;
    r.root = rnd[ROOT_W-1:0];
    r.conv = conv;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    root_expect_t want;
    if (!rst_ni) begin
      coef_a  = COEF_CUBIC_RST;
      coef_b  = COEF_SQUARE_RST;
      coef_c  = COEF_LINEAR_RST;
      tol     = TOLERANCE_RST;
      fails   = 0;
      pending = 0;
      expected_roots.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_COEF_CUBIC:  coef_a = cfg_data_i;
          CFG_COEF_SQUARE: coef_b = cfg_data_i;
          CFG_COEF_LINEAR: coef_c = cfg_data_i;
          CFG_TOLERANCE:   tol    = cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end
      // results first, so a result never pairs with an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_roots.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t: result with no transaction pending: root %0d conv %0b",
                     $realtime, root_rounded_i, converged_i);
        end else begin
          want = expected_roots.pop_front();
          pending--;
          if (want.root !== root_rounded_i || want.conv !== converged_i) begin
            fails++;
            if (fails <= 10)
              $display("%t: root mismatch: exp root %0d conv %0b, got root %0d conv %0b",
                       $realtime, want.root, want.conv, root_rounded_i, converged_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_roots.push_back(bisect_root(constant_term_i));
        pending++;
      end
    end
  end

endmodule

>>> tb/sv/tb_cubic_root_bisection_core.sv
// testbench top: stimulus, flow control and verdict for the cubic root bisection core
`timescale 1ns / 1ps
module tb_cubic_root_bisection_core;
  import cbr_pkg::*;

  localparam int unsigned ITER   = ITERATIONS_DEF;
  localparam int unsigned UB     = UPPER_BOUND_DEF;
  // worst case search time plus margin, used for the settle time at the end
  localparam int unsigned SETTLE = ITER * 16 + 64;
  localparam int unsigned PHASE_ITEMS = 219;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i = '0;
  logic [COEF_W-1:0]        cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [COEF_W-1:0] constant_term_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [ROOT_W-1:0]        root_rounded_o;
  logic                     converged_o;

  int fail_count;
  int pending;

  // coefficients as raw Q16.16 integers, kept as reals to aim items at real roots
  real coef_a_r, coef_b_r, coef_c_r;
  // sender burst bookkeeping
  int  burst_left;

  cubic_root_bisection_core #(
    .ITERATIONS (ITER),
    .UPPER_BOUND(UB)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .constant_term_i(constant_term_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .root_rounded_o (root_rounded_o),
    .converged_o    (converged_o)
  );

  cbr_checker #(
    .ITERATIONS (ITER),
    .UPPER_BOUND(UB)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .constant_term_i(constant_term_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .root_rounded_i (root_rounded_o),
    .converged_i    (converged_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop, reported as a mismatch
  initial begin
    #(64'd50_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side back pressure: the stall mode is redrawn at random periodically
  //   0: always ready, 1: coin flip, 2: mostly stalled, 3: periodic single-cycle ready pulses
  int ready_mode = 0;
  int ready_cnt  = 0;
  always @(negedge clk_i) begin
    if (ready_cnt % 64 == 0) ready_mode = $urandom_range(0, 3);
    ready_cnt++;
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= $urandom_range(0, 1);
      2:       out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= (ready_cnt % 5 == 0);
    endcase
  end

  // one register write; valid is left high so back to back writes need no toggle
  task automatic cfg_write(input cfg_reg_e idx, input logic [COEF_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // full register set; only called while nothing is in flight
  task automatic program_regs(input logic signed [COEF_W-1:0] a,
                              input logic signed [COEF_W-1:0] b,
                              input logic signed [COEF_W-1:0] c,
                              input logic [COEF_W-1:0] tol);
    cfg_write(CFG_COEF_CUBIC, a);
    cfg_write(CFG_COEF_SQUARE, b);
    cfg_write(CFG_COEF_LINEAR, c);
    cfg_write(CFG_TOLERANCE, tol);
    cfg_valid_i <= 1'b0;
    coef_a_r = real'(a);
    coef_b_r = real'(b);
    coef_c_r = real'(c);
  endtask

  // hold off the sender until every outstanding root has come back
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // one input transaction, then maybe a gap; a zero gap keeps valid high
  task automatic send_term(input logic signed [COEF_W-1:0] d);
    int gap;
    in_valid_i      <= 1'b1;
    constant_term_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 7) == 0) ? $urandom_range(20, 500) : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // random phase: mostly constant terms aimed at a real root in [0, UB], rest raw noise
  task automatic random_phase(input int count);
    real    r, dr;
    longint dl;
    logic signed [COEF_W-1:0] d;
    for (int n = 0; n < count; n++) begin
      // one mid-phase pause until the result queue is empty
      if (n == count / 2) drain();
      if ($urandom_range(0, 4) != 0) begin
        r  = real'($urandom_range(0, UB * 1000)) / 1000.0;
        dr = -(coef_a_r * r * r * r + coef_b_r * r * r + coef_c_r * r);
        dr = dr + real'($urandom_range(0, 32)) - 16.0;
        if (dr > 2147483647.0) dr = 2147483647.0;
        if (dr < -2147483648.0) dr = -2147483648.0;
        dl = longint'(dr);
        d  = dl[COEF_W-1:0];
      end else begin
        d = $urandom();
      end
      send_term(d);
    end
  endtask

  initial begin
    burst_left = 0;
    coef_a_r   = real'(COEF_CUBIC_RST);
    coef_b_r   = real'(COEF_SQUARE_RST);
    coef_c_r   = real'(COEF_LINEAR_RST);
    rst_ni     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset coefficients: f(x) = x + d, tolerance 7
    send_term(32'sd0);                      // zero at the lower end
    send_term(32'sh7FFF_FFFF);              // most positive term, no sign change
    send_term(32'sh8000_0000);              // most negative term
    send_term(-32'sd1);
    send_term(32'sd1);
    send_term(-32'sd983040);                // root exactly at the first midpoint
    send_term(-32'sd655360);                // root at 10
    send_term(-32'sd1966080);               // root at the upper end
    send_term(-32'sd1966081);               // root just past the upper end
    send_term(-32'sd32768);                 // root at 0.5, rounds up
    send_term(-32'sd491520);                // root at 7.5
    drain();

    // zero tolerance never converges, even on an exact zero
    program_regs(COEF_CUBIC_RST, COEF_SQUARE_RST, COEF_LINEAR_RST, 32'd0);
    send_term(-32'sd983040);
    send_term(-32'sd655360);
    send_term(32'sh8000_0000);
    drain();

    // pure cubic x^3 + d with the widest tolerance
    program_regs(32'sd65536, 32'sd0, 32'sd0, 32'h0000_FFFF);
    send_term(-32'sd65536000);              // root at 10
    send_term(-32'sd1769472000);            // root at 30
    send_term(32'sd5);
    send_term(-32'sd1);
    drain();

    // moderate random coefficients, small tolerance
    program_regs(int'($urandom_range(0, 8192)) - 4096,
                 int'($urandom_range(0, 131072)) - 65536,
                 int'($urandom_range(0, 2097152)) - 1048576,
                 {16'($urandom()), 16'($urandom_range(1, 64))});
    random_phase(PHASE_ITEMS);
    drain();

    // coefficient extremes, widest tolerance with junk above it
    program_regs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, {16'($urandom()), 16'hFFFF});
    random_phase(PHASE_ITEMS);
    drain();

    // opposite extremes, zero tolerance
    program_regs(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'd0);
    random_phase(PHASE_ITEMS);
    drain();

    // moderate coefficients, any tolerance
    program_regs(int'($urandom_range(0, 8192)) - 4096,
                 int'($urandom_range(0, 131072)) - 65536,
                 int'($urandom_range(0, 2097152)) - 1048576, $urandom());
    random_phase(PHASE_ITEMS);
    drain();

    // linear only, either slope sign
    program_regs(32'sd0, 32'sd0, int'($urandom_range(0, 524288)) - 262144,
                 32'($urandom_range(0, 16)));
    random_phase(PHASE_ITEMS);
    drain();

    // anything goes
    program_regs($urandom(), $urandom(), $urandom(), $urandom());
    random_phase(PHASE_ITEMS);
    drain();

    // catch any stray result after the queue empties
    repeat (SETTLE) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cbr_pkg.sv
rtl/cubic_root_bisection_core.sv
tb/sv/cbr_checker.sv
tb/sv/tb_cubic_root_bisection_core.sv
